>>> hw/rtl/hbss_pkg.sv
// ----------------------------------------------------------------------------
// hbss_pkg
// Shared types and constants of the exposure bracket sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hbss_pkg;

  // field widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CenterW = 12;
  localparam int unsigned EvW     = 5;
  localparam int unsigned GapW    = 20;
  localparam int unsigned CfgW    = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ShotW   = 2;
  localparam int unsigned ThrW    = GapW + 1;
  // longest exposure is 1000 * 4095 * 31 ms, fits 27 bits
  localparam int unsigned ExpW    = 27;
  localparam int unsigned NumShots = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCenter    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEv        = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGap       = 2'd2;
  localparam logic [CfgIdxW-1:0] RegFocusLead = 2'd3;

  // register reset values
  localparam logic [CenterW-1:0] CenterReset    = 12'd1;
  localparam logic [EvW-1:0]     EvReset        = 5'd1;
  localparam logic [GapW-1:0]    GapReset       = 20'd1000;
  localparam logic [GapW-1:0]    FocusLeadReset = 20'd500;

  // input command codes
  localparam logic CmdPoll    = 1'b0;
  localparam logic CmdRestart = 1'b1;

  // shot count once the bracket is complete
  localparam logic [ShotW-1:0] ShotsAll = ShotW'(NumShots);

  // timing limits derived from configuration
  typedef struct packed {
    logic [GapW-1:0] gap;
    logic [ThrW-1:0] trig_thr;
    logic [ExpW-1:0] exp_short;
    logic [ExpW-1:0] exp_mid;
    logic [ExpW-1:0] exp_long;
  } hbss_limits_t;

  // one result item
  typedef struct packed {
    logic             done;
    logic [ShotW-1:0] shots;
    logic             focus;
    logic             release_p;
    logic             trigger;
  } hbss_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/hbss_limits.sv
// ----------------------------------------------------------------------------
// hbss_limits
// Configuration registers and registered exposure lengths and thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbss_limits
  import hbss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [CfgIdxW-1:0] wr_index,
  input  wire logic [CfgW-1:0]    wr_data,
  output hbss_limits_t            limits
);

  logic [CenterW-1:0] center;
  logic [EvW-1:0]     ev;
  logic [GapW-1:0]    gap;
  logic [GapW-1:0]    focus_lead;

  logic signed [CenterW:0]   c_s;
  logic signed [EvW:0]       f_short;
  logic signed [EvW:0]       f_long;
  logic signed [CenterW+EvW+1:0] p_short;
  logic signed [CenterW+EvW+1:0] p_long;
  logic signed [ExpW:0]      len_short;
  logic signed [ExpW:0]      len_long;
  logic [ExpW-1:0]           len_mid;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center     <= CenterReset;
      ev         <= EvReset;
      gap        <= GapReset;
      focus_lead <= FocusLeadReset;
    end else if (wr_en) begin
      unique case (wr_index)
        RegCenter:    center     <= wr_data[CenterW-1:0];
        RegEv:        ev         <= wr_data[EvW-1:0];
        RegGap:       gap        <= wr_data[GapW-1:0];
        RegFocusLead: focus_lead <= wr_data[GapW-1:0];
        default: ;
      endcase
    end
  end

  // short = 500*c*(2-ev), long = 1000*c*(1+2*ev)
  always_comb begin
    c_s       = $signed({1'b0, center});
    f_short   = $signed(6'sd2) - $signed({ev[EvW-1], ev});
    f_long    = $signed({ev, 1'b1});
    p_short   = c_s * f_short;
    p_long    = c_s * f_long;
    len_short = $signed({{(ExpW+1-(CenterW+EvW+2)){p_short[CenterW+EvW+1]}}, p_short})
                * $signed(28'sd500);
    len_long  = $signed({{(ExpW+1-(CenterW+EvW+2)){p_long[CenterW+EvW+1]}}, p_long})
                * $signed(28'sd1000);
    len_mid   = ExpW'({15'd0, center} * 27'd1000);
  end

  // registered limits, negative lengths clamp to zero
  always_ff @(posedge clk) begin
    limits.gap       <= gap;
    limits.trig_thr  <= {1'b0, gap} + {1'b0, focus_lead};
    limits.exp_short <= len_short[ExpW] ? '0 : len_short[ExpW-1:0];
    limits.exp_mid   <= len_mid;
    limits.exp_long  <= len_long[ExpW] ? '0 : len_long[ExpW-1:0];
  end

endmodule

`default_nettype wire

>>> hw/rtl/hbss_core.sv
// ----------------------------------------------------------------------------
// hbss_core
// Bracket state and the per-poll focus, trigger and release decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbss_core
  import hbss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic             cmd,
  input  wire logic [TimeW-1:0] now,
  input  hbss_limits_t          limits,
  output hbss_result_t          result
);

  logic [TimeW-1:0] last_release_time;
  logic [TimeW-1:0] open_time;
  logic             shutter_open;
  logic [ShotW-1:0] shot_count;
  logic             first_poll;

  logic [TimeW-1:0] last_release_time_next;
  logic [TimeW-1:0] open_time_next;
  logic             shutter_open_next;
  logic [ShotW-1:0] shot_count_next;
  logic             first_poll_next;

  logic [TimeW-1:0] ref_time;
  logic [TimeW-1:0] since_rel;
  logic [TimeW-1:0] since_open;
  logic [ExpW-1:0]  exp_now;

  // exposure length for the current shot
  always_comb begin
    case (shot_count)
      2'd0:    exp_now = limits.exp_short;
      2'd1:    exp_now = limits.exp_mid;
      default: exp_now = limits.exp_long;
    endcase
  end

  // decision and next state
  always_comb begin
    last_release_time_next = last_release_time;
    open_time_next         = open_time;
    shutter_open_next      = shutter_open;
    shot_count_next        = shot_count;
    first_poll_next        = first_poll;
    result                 = '0;
    ref_time   = first_poll ? now : last_release_time;
    since_rel  = now - ref_time;
    since_open = now - open_time;

    if (cmd == CmdRestart) begin
      shot_count_next = '0;
      first_poll_next = 1'b1;
    end else if (shot_count != ShotsAll) begin
      // first poll restarts the gap timer with a release
      result.release_p       = first_poll;
      first_poll_next        = 1'b0;
      last_release_time_next = ref_time;
      if ((since_rel > {{(TimeW-ThrW){1'b0}}, limits.trig_thr}) && !shutter_open) begin
        result.trigger    = 1'b1;
        shutter_open_next = 1'b1;
        open_time_next    = now;
      end else if (shutter_open) begin
        if (since_open >= {{(TimeW-ExpW){1'b0}}, exp_now}) begin
          result.release_p       = 1'b1;
          shot_count_next        = shot_count + 2'd1;
          shutter_open_next      = 1'b0;
          last_release_time_next = now;
        end
      end else if (since_rel > {{(TimeW-GapW){1'b0}}, limits.gap}) begin
        result.focus = 1'b1;
      end
    end

    result.shots = shot_count_next;
    result.done  = (shot_count_next == ShotsAll);
  end

  // state update once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      last_release_time <= '0;
      open_time         <= '0;
      shutter_open      <= 1'b0;
      shot_count        <= '0;
      first_poll        <= 1'b1;
    end else if (advance) begin
      last_release_time <= last_release_time_next;
      open_time         <= open_time_next;
      shutter_open      <= shutter_open_next;
      shot_count        <= shot_count_next;
      first_poll        <= first_poll_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hdr_bracket_shutter_sequencer.sv
// ----------------------------------------------------------------------------
// hdr_bracket_shutter_sequencer
// Three-shot exposure bracket sequencer with stream input and output.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on s_* is a poll (s_tuser = 0) with the current
//   millisecond time in s_tdata, or a restart (s_tuser = 1). Every input gives
//   exactly one output transaction on m_* with the focus, trigger and release
//   pulses for that poll plus the shot count and a bracket-complete flag.
//   Each input passes through an input register, then the decision logic
//   feeds the output register together with the bracket state. Throughput
//   is one transaction per cycle while the output is taken; the bracket
//   state loop (32-bit time difference and compare) is not pipelined.
//   Configuration is written on cfg_* while no transaction is in flight;
//   cfg_ready is always high and derived exposure lengths settle in the limits
//   register after the configuration register takes the write.
//   Reset restores the register defaults, clears shot count and shutter
//   state and arms the first-poll release. When m_tready is low the output
//   holds, one more input is absorbed if the input register is empty, then
//   s_tready drops until the output is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hdr_bracket_shutter_sequencer
  import hbss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_data,
  // input stream
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [TimeW-1:0]   s_tdata,   // [31:0] now_ms
  input  wire logic               s_tuser,   // [0] command
  // output stream
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [7:0]              m_tdata    // [0] trigger_pulse, [1] release_pulse,
                                             // [2] focus_pulse, [4:3] shots_done,
                                             // [5] bracket_done, [7:6] zero
);

  hbss_limits_t     limits;
  hbss_result_t     result;
  hbss_result_t     out_result;
  logic             in_valid;
  logic             in_cmd;
  logic [TimeW-1:0] in_now;
  logic             out_free;
  logic             advance;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign advance   = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;

  hbss_limits u_limits (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .limits   (limits)
  );

  hbss_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cmd     (in_cmd),
    .now     (in_now),
    .limits  (limits),
    .result  (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd <= s_tuser;
      in_now <= s_tdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tdata = {2'b00, out_result};

  // a trigger never shares a poll with a release or focus pulse
  a_trig_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && (m_tdata[1] || m_tdata[2])))
    else $error("trigger coincides with release or focus");

  // bracket flag tracks a full shot count
  a_done_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[5] == (m_tdata[4:3] == ShotsAll)))
    else $error("bracket_done disagrees with shots_done");

  // a held input transaction stays until the output side frees up
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_free) |=> (in_valid && $stable(in_now) && $stable(in_cmd)))
    else $error("input register lost a pending transaction");

endmodule

`default_nettype wire

>>> tb/hbss_bracket_checker.sv
// ----------------------------------------------------------------------------
// hbss_bracket_checker
// Watches the configuration, input and output channels of the exposure
// bracket sequencer, predicts the pulses and shot count of every accepted
// input transaction and compares them in order with the output transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbss_bracket_checker
  import hbss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [TimeW-1:0]   s_tdata,   // [31:0] now_ms
  input  logic               s_tuser,   // [0] command
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [7:0]         m_tdata,   // [0] trigger, [1] release, [2] focus,
                                        // [4:3] shots_done, [5] bracket_done
  output int                 fail_count,
  output int                 open_results
);

  // shadow of the configuration registers
  logic [CenterW-1:0]      center_s;
  logic signed [EvW-1:0]   ev_s;
  logic [GapW-1:0]         gap_v;
  logic [GapW-1:0]         lead_v;

  // shadow of the bracket state
  logic [TimeW-1:0]        rel_stamp;
  logic [TimeW-1:0]        open_stamp;
  logic                    shutter_is_open;
  logic [ShotW-1:0]        shots_taken;
  logic                    awaiting_first;

  hbss_result_t            pulses_due_q [$];
  int                      result_seq;

  initial begin
    fail_count   = 0;
    open_results = 0;
    result_seq   = 0;
  end

  // exposure length in ms for a shot, negative lengths clamp to zero
  function automatic longint exposure_for(logic [ShotW-1:0] shot);
    longint c;
    longint ev;
    longint len;
    c  = center_s;
    ev = ev_s;
    if (shot == 0)
      len = 1000 * c - 500 * ev * c;
    else if (shot == 1)
      len = 1000 * c;
    else
      len = 1000 * c + 2000 * ev * c;
    if (len < 0) len = 0;
    return len;
  endfunction

  // advance the bracket state by one input transaction
  function automatic hbss_result_t bracket_advance(logic cmd, logic [TimeW-1:0] now_v);
    hbss_result_t r;
    logic [TimeW-1:0] since_rel;
    logic [TimeW-1:0] since_open;
    longint sr;
    longint so;
    longint trig_thr;
    r = '0;
    if (cmd == CmdRestart) begin
      shots_taken    = '0;
      awaiting_first = 1'b1;
    end else if (shots_taken < ShotsAll) begin
      if (awaiting_first) begin
        rel_stamp      = now_v;
        r.release_p    = 1'b1;
        awaiting_first = 1'b0;
      end
      since_rel = now_v - rel_stamp;
      sr        = since_rel;
      trig_thr  = longint'(gap_v) + longint'(lead_v);
      if (sr > trig_thr && !shutter_is_open) begin
        r.trigger       = 1'b1;
        shutter_is_open = 1'b1;
        open_stamp      = now_v;
      end else if (shutter_is_open) begin
        since_open = now_v - open_stamp;
        so         = since_open;
        if (so >= exposure_for(shots_taken)) begin
          r.release_p     = 1'b1;
          shots_taken     = shots_taken + 1'b1;
          shutter_is_open = 1'b0;
          rel_stamp       = now_v;
        end
      end else if (sr > longint'(gap_v)) begin
        r.focus = 1'b1;
      end
    end
    r.shots = shots_taken;
    r.done  = (shots_taken == ShotsAll);
    return r;
  endfunction

  // one line per mismatch, and count it
  task automatic note_mismatch(string what, int got, int want);
    $display("mismatch at result %0d, %s: got %0d, expected %0d",
             result_seq, what, got, want);
    fail_count++;
  endtask

  // compare an output transaction with the oldest prediction
  task automatic compare_result(logic [7:0] word);
    hbss_result_t got;
    hbss_result_t want;
    got = hbss_result_t'(word[5:0]);
    if (pulses_due_q.size() == 0) begin
      note_mismatch("result with nothing pending", int'(word), 0);
    end else begin
      want = pulses_due_q.pop_front();
      if (got.trigger != want.trigger)
        note_mismatch("trigger_pulse", int'(got.trigger), int'(want.trigger));
      if (got.release_p != want.release_p)
        note_mismatch("release_pulse", int'(got.release_p), int'(want.release_p));
      if (got.focus != want.focus)
        note_mismatch("focus_pulse", int'(got.focus), int'(want.focus));
      if (got.shots != want.shots)
        note_mismatch("shots_done", int'(got.shots), int'(want.shots));
      if (got.done != want.done)
        note_mismatch("bracket_done", int'(got.done), int'(want.done));
      if (word[7:6] != 2'b00)
        note_mismatch("pad bits", int'(word[7:6]), 0);
    end
    result_seq++;
  endtask

  // monitor all three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      center_s        = CenterReset;
      ev_s            = EvReset;
      gap_v           = GapReset;
      lead_v          = FocusLeadReset;
      rel_stamp       = '0;
      open_stamp      = '0;
      shutter_is_open = 1'b0;
      shots_taken     = '0;
      awaiting_first  = 1'b1;
      pulses_due_q.delete();
      open_results    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegCenter:    center_s = cfg_data[CenterW-1:0];
          RegEv:        ev_s     = cfg_data[EvW-1:0];
          RegGap:       gap_v    = cfg_data[GapW-1:0];
          RegFocusLead: lead_v   = cfg_data[GapW-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) compare_result(m_tdata);
      if (s_tvalid && s_tready) pulses_due_q.push_back(bracket_advance(s_tuser, s_tdata));
      open_results = pulses_due_q.size();
    end
  end

endmodule

>>> tb/tb_hdr_bracket_shutter_sequencer.sv
// ----------------------------------------------------------------------------
// tb_hdr_bracket_shutter_sequencer
// Drives polls and restarts into the bracket sequencer under several register
// settings and idle patterns; a checker beside the block predicts and compares
// every output transaction, and this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hdr_bracket_shutter_sequencer;
  import hbss_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int NumPhases    = 9;
  localparam int ItemsPerPhase = 200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TimeW-1:0]   s_tdata = '0;
  logic               s_tuser = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;

  int                 fail_count;
  int                 open_results;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;

  // stimulus view of the registers, used to pick interesting time steps
  logic [CenterW-1:0]    cur_center = CenterReset;
  logic signed [EvW-1:0] cur_ev = EvReset;
  logic [GapW-1:0]       cur_gap = GapReset;
  logic [GapW-1:0]       cur_lead = FocusLeadReset;
  logic [TimeW-1:0]      step_mark [5];
  logic [TimeW-1:0]      wall_ms;

  hdr_bracket_shutter_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  hbss_bracket_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // run limit
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("tb_hdr_bracket_shutter_sequencer failed");
    $finish;
  end

  // time steps around the thresholds of the current setting
  function automatic void refresh_marks();
    longint c;
    longint ev;
    longint short_len;
    longint long_len;
    c  = cur_center;
    ev = cur_ev;
    short_len = 1000 * c - 500 * ev * c;
    if (short_len < 0) short_len = 0;
    long_len = 1000 * c + 2000 * ev * c;
    if (long_len < 0) long_len = 0;
    step_mark[0] = TimeW'(cur_gap);
    step_mark[1] = TimeW'(longint'(cur_gap) + longint'(cur_lead) + 1);
    step_mark[2] = TimeW'(1000 * c);
    step_mark[3] = TimeW'(short_len);
    step_mark[4] = TimeW'(long_len);
  endfunction

  // one input transaction, with random idle cycles ahead of it
  task automatic push_item(logic cmd, logic [TimeW-1:0] now_v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= now_v;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // stop sending and wait until every pending result is out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (open_results != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // reprogram all registers while the block is idle
  task automatic apply_setting(logic [CfgW-1:0] d_center, logic [CfgW-1:0] d_ev,
                               logic [CfgW-1:0] d_gap, logic [CfgW-1:0] d_lead);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(RegCenter, d_center);
    write_reg(RegEv, d_ev);
    write_reg(RegGap, d_gap);
    write_reg(RegFocusLead, d_lead);
    cur_center = d_center[CenterW-1:0];
    cur_ev     = d_ev[EvW-1:0];
    cur_gap    = d_gap[GapW-1:0];
    cur_lead   = d_lead[GapW-1:0];
    refresh_marks();
    repeat (2) @(posedge clk);
  endtask

  // one random transaction: mostly bracket-shaped polls, some noise
  task automatic random_item(int run_pos);
    int pick;
    logic [TimeW-1:0] step;
    pick = $urandom_range(99);
    if (run_pos == 0 || pick < 4) begin
      push_item(CmdRestart, $urandom);
    end else if (pick < 12) begin
      wall_ms = $urandom;
      push_item(CmdPoll, wall_ms);
    end else begin
      if (pick < 45)
        step = step_mark[$urandom_range(4)] + $urandom_range(2) - 1;
      else if (pick < 75)
        step = $urandom_range(3);
      else
        step = $urandom_range(step_mark[$urandom_range(4)]);
      wall_ms = wall_ms + step;
      push_item(CmdPoll, wall_ms);
    end
  endtask

  initial begin
    int run_pos;
    refresh_marks();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk through one bracket at the reset setting
    push_item(CmdPoll, 32'd0);        // first poll release
    push_item(CmdPoll, 32'd1000);     // gap reached but not exceeded
    push_item(CmdPoll, 32'd1001);     // focus
    push_item(CmdPoll, 32'd1500);     // focus, trigger threshold not exceeded
    push_item(CmdPoll, 32'd1501);     // trigger
    push_item(CmdPoll, 32'd2000);     // one ms short of the short exposure
    push_item(CmdPoll, 32'd2001);     // release, first shot
    push_item(CmdPoll, 32'd3502);     // trigger
    push_item(CmdPoll, 32'd4502);     // release, second shot
    push_item(CmdPoll, 32'd6003);     // trigger
    push_item(CmdPoll, 32'd9003);     // release, bracket complete
    push_item(CmdPoll, 32'd20000);    // complete bracket ignores polls
    push_item(CmdRestart, 32'hFFFF_FFFF);
    push_item(CmdPoll, 32'hFFFF_FFFF);
    push_item(CmdPoll, 32'h0000_05DC); // elapsed time wraps through zero
    push_item(CmdRestart, 32'h0000_0000); // restart with the shutter open
    push_item(CmdPoll, 32'h0000_0800); // first-poll and exposure release merge
    push_item(CmdPoll, 32'h0000_0E00);
    push_item(CmdRestart, 32'h5555_5555);
    push_item(CmdRestart, 32'hAAAA_AAAA);
    push_item(CmdPoll, 32'h0000_1300); // merged release again
    wall_ms = 32'h0000_1300;

    // random phases across settings and idle patterns
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: apply_setting(20'd0, 20'h10, 20'd0, 20'd0);
        1: apply_setting(20'd4095, 20'h0F, 20'hFFFFF, 20'hFFFFF);
        2: apply_setting(20'd3600, 20'h18, 20'd600000, 20'd600000);
        3: apply_setting(20'd3600, 20'd8, 20'd0, 20'd1);
        4: apply_setting(20'd2, 20'd3, 20'd5, 20'd7);
        default: apply_setting(CfgW'($urandom), CfgW'($urandom),
                               CfgW'($urandom), CfgW'($urandom));
      endcase
      if (ph < 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 76;
      end else if (ph < 6) begin
        send_idle_pct = 76;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_pos = 0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // hold off once until the output side has caught up
        if (ph == 0 && n == ItemsPerPhase / 2) wait_drained();
        random_item(run_pos);
        run_pos = (run_pos == 24) ? 0 : run_pos + 1;
      end
    end

    // drain and let the pipeline settle
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("tb_hdr_bracket_shutter_sequencer passed");
    else
      $display("tb_hdr_bracket_shutter_sequencer failed");
    $finish;
  end

endmodule
